// File: hdl/alm_pkg.sv
package alm_pkg;

    localparam int CHUNK_MAX = 512;
    localparam int CCNT_W    = $clog2(CHUNK_MAX + 1);
    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
    localparam int OUT_W     = 64;

    localparam logic [14:0] MAG_MAX     = 15'h7FFF;
    localparam logic [23:0] CSUM_MAX    = 24'hFFFFFF;
    localparam logic [46:0] TSUM_MAX    = 47'h7FFF_FFFF_FFFF;
    localparam logic [6:0]  LEVEL_MAX   = 7'd100;
    localparam logic [14:0] NOISE_RST   = 15'd20;
    localparam logic [14:0] SCALE_RST   = 15'd80;
    // x / 10 == (x * 205) >> 11 for x <= 1000
    localparam logic [7:0]  SMOOTH_MUL  = 8'd205;

    localparam logic CFG_NOISE_FLOOR = 1'b0;
    localparam logic CFG_LEVEL_SCALE = 1'b1;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_START  = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        DOP_CAVG,
        DOP_MAVG,
        DOP_MPEAK,
        DOP_TAVG,
        DOP_MTAVG
    } t_div_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOTAL,
        S_CAVG,
        S_MAVG,
        S_MPEAK,
        S_SMOOTH,
        S_TAVG,
        S_MTAVG,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    total_upd;
        logic    div_start;
        t_div_op div_op;
        logic    level_upd;
        logic    clear_chunk;
        logic    load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic chunk_end;
        logic div_done;
        logic out_free;
    } t_ctl_sts;

    function automatic logic [6:0] cap_level(input logic [DIV_N_W-1:0] q);
        cap_level = (q > DIV_N_W'(LEVEL_MAX)) ? LEVEL_MAX : q[6:0];
    endfunction

endpackage

// File: hdl/alm_ctrl.sv
module alm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  alm_pkg::t_ctl_sts i_sts,
    output alm_pkg::t_ctl_cmd o_cmd
);
    import alm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.chunk_end ? S_TOTAL : S_OUT;
                end
            end
            S_TOTAL: begin
                o_cmd.total_upd = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DOP_CAVG;
                n_state         = S_CAVG;
            end
            S_CAVG: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DOP_MAVG;
                    n_state         = S_MAVG;
                end
            end
            S_MAVG: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DOP_MPEAK;
                    n_state         = S_MPEAK;
                end
            end
            S_MPEAK: begin
                if (i_sts.div_done) begin
                    n_state = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                o_cmd.level_upd = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DOP_TAVG;
                n_state         = S_TAVG;
            end
            S_TAVG: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DOP_MTAVG;
                    n_state         = S_MTAVG;
                end
            end
            S_MTAVG: begin
                if (i_sts.div_done) begin
                    o_cmd.clear_chunk = 1'b1;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/alm_datapath.sv
module alm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [31:0]                   i_s_tdata,
    input  logic [1:0]                    i_s_tuser,
    input  logic                          i_s_tlast,
    output logic [alm_pkg::OUT_W-1:0]     o_m_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_index,
    input  logic [14:0]                   i_cfg_data,
    input  alm_pkg::t_ctl_cmd             i_cmd,
    output alm_pkg::t_ctl_sts             o_sts
);
    import alm_pkg::*;

    logic [14:0] r_noise, r_scale;
    logic        r_rec;
    logic [6:0]  r_level;
    logic [23:0] r_csum;
    logic [14:0] r_cpeak;
    logic [CCNT_W-1:0] r_ccnt;
    logic [31:0] r_tcnt;
    logic [46:0] r_tsum;
    logic [14:0] r_tpeak;
    logic [6:0]  r_avg_level;
    logic [14:0] r_avg, r_tavg;
    logic [6:0]  r_mavg, r_mhalf;

    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem, r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;
    t_div_op              r_op;

    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    t_action              act;
    logic [16:0]          mag_hi, mag_lo, mag_max;
    logic [14:0]          mag;
    logic [24:0]          csum_add;
    logic [CCNT_W-1:0]    ccnt_inc;
    logic [32:0]          tcnt_add;
    logic [47:0]          tsum_add;
    logic [DIV_N_W-1:0]   div_n;
    logic [DIV_D_W-1:0]   div_d;
    logic [14:0]          scale_eff;
    logic [6:0]           target;
    logic [10:0]          smooth_num;
    logic [18:0]          smooth_prod;
    logic [DIV_D_W:0]     trial;
    logic                 ge;
    logic [DIV_N_W-1:0]   quo_next;

    assign act      = t_action'(i_s_tuser);
    assign mag_hi   = i_s_tdata[31] ? (17'h10000 - {1'b0, i_s_tdata[31:16]})
                                    : {1'b0, i_s_tdata[31:16]};
    assign mag_lo   = i_s_tdata[15] ? (17'h10000 - {1'b0, i_s_tdata[15:0]})
                                    : {1'b0, i_s_tdata[15:0]};
    assign mag_max  = (mag_hi > mag_lo) ? mag_hi : mag_lo;
    assign mag      = (mag_max > {2'b0, MAG_MAX}) ? MAG_MAX : mag_max[14:0];
    assign csum_add = {1'b0, r_csum} + {10'b0, mag};
    assign ccnt_inc = r_ccnt + CCNT_W'(1);
    assign tcnt_add = {1'b0, r_tcnt} + 33'(r_ccnt);
    assign tsum_add = {1'b0, r_tsum} + 48'(r_csum);
    assign scale_eff = (r_scale == '0) ? 15'd1 : r_scale;
    assign target   = (r_mavg > r_mhalf) ? r_mavg : r_mhalf;
    assign smooth_num = (target > r_level)
                      ? (11'(r_level) * 11'd3 + 11'(target) * 11'd7)
                      : (11'(r_level) * 11'd9 + 11'(target));
    assign smooth_prod = 19'(smooth_num) * 19'(SMOOTH_MUL);

    always_comb begin
        div_n = '0;
        div_d = DIV_D_W'(scale_eff);
        case (i_cmd.div_op)
            DOP_CAVG: begin
                div_n = DIV_N_W'(r_csum);
                div_d = DIV_D_W'(r_ccnt);
            end
            DOP_MAVG: begin
                div_n = (r_avg > r_noise) ? DIV_N_W'(r_avg - r_noise) : '0;
            end
            DOP_MPEAK: begin
                div_n = (r_cpeak > r_noise) ? DIV_N_W'(r_cpeak - r_noise) : '0;
            end
            DOP_TAVG: begin
                div_n = DIV_N_W'(r_tsum);
                div_d = r_tcnt;
            end
            DOP_MTAVG: begin
                div_n = (r_tavg > r_noise) ? DIV_N_W'(r_tavg - r_noise) : '0;
            end
            default: begin
                div_n = '0;
            end
        endcase
    end

    assign trial    = {r_rem, r_quo[DIV_N_W-1]};
    assign ge       = trial >= {1'b0, r_dvs};
    assign quo_next = {r_quo[DIV_N_W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_op  <= i_cmd.div_op;
            r_quo <= div_n;
            r_rem <= '0;
            r_dvs <= div_d;
            r_cnt <= DIV_CNT_W'(DIV_N_W);
        end else if (r_busy) begin
            r_quo <= quo_next;
            r_rem <= ge ? DIV_D_W'(trial - {1'b0, r_dvs}) : trial[DIV_D_W-1:0];
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
            case (r_op)
                DOP_CAVG:  r_avg   <= quo_next[14:0];
                DOP_MAVG:  r_mavg  <= cap_level(quo_next);
                DOP_MPEAK: r_mhalf <= cap_level(quo_next) >> 1;
                DOP_TAVG:  r_tavg  <= quo_next[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise     <= NOISE_RST;
            r_scale     <= SCALE_RST;
            r_rec       <= 1'b0;
            r_level     <= '0;
            r_csum      <= '0;
            r_cpeak     <= '0;
            r_ccnt      <= '0;
            r_tcnt      <= '0;
            r_tsum      <= '0;
            r_tpeak     <= '0;
            r_avg_level <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_NOISE_FLOOR) begin
                    r_noise <= i_cfg_data;
                end else begin
                    r_scale <= i_cfg_data;
                end
            end
            if (i_cmd.accept) begin
                case (act)
                    ACT_START: begin
                        r_rec       <= 1'b1;
                        r_level     <= '0;
                        r_csum      <= '0;
                        r_cpeak     <= '0;
                        r_ccnt      <= '0;
                        r_tcnt      <= '0;
                        r_tsum      <= '0;
                        r_tpeak     <= '0;
                        r_avg_level <= '0;
                    end
                    ACT_STOP: begin
                        r_rec   <= 1'b0;
                        r_level <= '0;
                        r_csum  <= '0;
                        r_cpeak <= '0;
                        r_ccnt  <= '0;
                    end
                    ACT_SAMPLE: begin
                        if (r_rec) begin
                            r_csum  <= csum_add[24] ? CSUM_MAX : csum_add[23:0];
                            r_cpeak <= (mag > r_cpeak) ? mag : r_cpeak;
                            r_ccnt  <= ccnt_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.total_upd) begin
                r_tcnt  <= tcnt_add[32] ? 32'hFFFF_FFFF : tcnt_add[31:0];
                r_tsum  <= tsum_add[47] ? TSUM_MAX : tsum_add[46:0];
                r_tpeak <= (r_cpeak > r_tpeak) ? r_cpeak : r_tpeak;
            end
            if (i_cmd.level_upd) begin
                r_level <= smooth_prod[17:11];
            end
            if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                if (r_op == DOP_MTAVG) begin
                    r_avg_level <= cap_level(quo_next);
                end
            end
            if (i_cmd.clear_chunk) begin
                r_csum  <= '0;
                r_cpeak <= '0;
                r_ccnt  <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {2'b0, r_rec, r_tcnt, r_tpeak, r_avg_level, r_level};
        end
    end

    assign o_sts.chunk_end = (act == ACT_SAMPLE) && r_rec
                           && (i_s_tlast || ccnt_inc >= CCNT_W'(CHUNK_MAX));
    assign o_sts.div_done  = r_done;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;

endmodule

// File: hdl/audio_level_meter_core.sv
// An input transaction is accepted only in idle. If it ends no chunk, the controller
// goes straight to the output state to load the result into the output register.
// A chunk-ending sample first runs five serial divides and one smoothing step on
// the shared one-bit-per-cycle divider. A new item is taken only after the previous
// result is loaded, and loading waits while the output register is full and stalled.
// Reset (synchronous, active low): idle, not recording, totals zero, registers 20/80.
module audio_level_meter_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [31:0]               i_s_tdata,   // [31:0] raw_sample
    input  logic [1:0]                i_s_tuser,   // [1:0] action
    input  logic                      i_s_tlast,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // [6:0] instant_level, [13:7] average_level, [28:14] peak_magnitude,
    // [60:29] samples_total, [61] recording, [63:62] zero
    output logic [alm_pkg::OUT_W-1:0] o_m_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [14:0]               i_cfg_data
);
    import alm_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    assign o_cfg_ready = 1'b1;

    alm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    alm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6:0] <= LEVEL_MAX) && (o_m_tdata[13:7] <= LEVEL_MAX))
        else $error("level above 100");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while previous item in progress");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.div_start, cmd.clear_chunk, cmd.load_out}))
        else $error("conflicting controller commands");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import alm_pkg::*;

    typedef struct packed {
        logic [6:0]  level;
        logic [6:0]  avg;
        logic [14:0] peak;
        logic [31:0] count;
        logic        rec;
    } t_meter;

    typedef struct {
        t_action     act;
        logic [31:0] data;
        logic        last;
        logic        typed;
        t_meter      want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [14:0] i_cfg_data;

    audio_level_meter_core i_dut (.*);

    // predicted meter state
    logic [14:0] floor_q, scale_q;
    logic        rec_q;
    logic [6:0]  level_q;
    logic [23:0] csum_q;
    logic [14:0] cpeak_q, tpeak_q;
    logic [12:0] ccnt_q;
    logic [31:0] tcnt_q;
    logic [46:0] tsum_q;

    t_meter meter_q[$];
    int     n_err, n_items, n_results, n_chunks;
    bit     quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [6:0] map_level(input longint unsigned x);
        longint unsigned sc, v;
        sc = (scale_q == 0) ? 1 : scale_q;
        if (x <= floor_q) return 7'd0;
        v = (x - floor_q) / sc;
        return (v > 100) ? 7'd100 : v[6:0];
    endfunction

    function automatic logic [15:0] half_mag(input logic [15:0] h);
        return h[15] ? 16'(17'h10000 - h) : {1'b0, h[14:0]};
    endfunction

    function automatic void close_chunk();
        longint unsigned t, m_avg, m_half, tgt;
        if (ccnt_q == 0) return;
        t = longint'(tcnt_q) + ccnt_q;
        tcnt_q = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        t = longint'(tsum_q) + csum_q;
        tsum_q = (t > TSUM_MAX) ? TSUM_MAX : t[46:0];
        if (cpeak_q > tpeak_q) tpeak_q = cpeak_q;
        m_avg = map_level(csum_q / ccnt_q);
        m_half = map_level(cpeak_q) / 2;
        tgt = (m_avg > m_half) ? m_avg : m_half;
        if (tgt > level_q) level_q = (level_q * 3 + tgt * 7) / 10;
        else level_q = (level_q * 9 + tgt) / 10;
        csum_q = '0; cpeak_q = '0; ccnt_q = '0;
        n_chunks++;
    endfunction

    function automatic t_meter meter_step(input t_action act, input logic [31:0] raw,
                                          input logic last);
        t_meter r;
        logic [15:0] a, b;
        longint unsigned s;
        case (act)
            ACT_START: begin
                rec_q = 1'b1; level_q = '0; csum_q = '0; cpeak_q = '0; ccnt_q = '0;
                tcnt_q = '0; tsum_q = '0; tpeak_q = '0;
            end
            ACT_STOP: begin
                rec_q = 1'b0; level_q = '0; csum_q = '0; cpeak_q = '0; ccnt_q = '0;
            end
            ACT_SAMPLE: if (rec_q) begin
                a = half_mag(raw[31:16]);
                b = half_mag(raw[15:0]);
                if (b > a) a = b;
                if (a > MAG_MAX) a = MAG_MAX;
                s = longint'(csum_q) + a;
                csum_q = (s > CSUM_MAX) ? CSUM_MAX : s[23:0];
                if (a[14:0] > cpeak_q) cpeak_q = a[14:0];
                ccnt_q++;
                if (last || ccnt_q >= CHUNK_MAX) close_chunk();
            end
            default: ;
        endcase
        r.level = level_q;
        r.avg   = (tcnt_q == 0) ? 7'd0 : map_level(tsum_q / tcnt_q);
        r.peak  = tpeak_q;
        r.count = tcnt_q;
        r.rec   = rec_q;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    always @(posedge i_clk) begin
        t_meter w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (meter_q.size() == 0) begin
                report("unexpected transaction", o_m_tdata, 0);
            end else begin
                w = meter_q.pop_front();
                if (o_m_tdata[6:0] != w.level) report("instant_level", o_m_tdata[6:0], w.level);
                if (o_m_tdata[13:7] != w.avg) report("average_level", o_m_tdata[13:7], w.avg);
                if (o_m_tdata[28:14] != w.peak)
                    report("peak_magnitude", o_m_tdata[28:14], w.peak);
                if (o_m_tdata[60:29] != w.count)
                    report("samples_total", o_m_tdata[60:29], w.count);
                if (o_m_tdata[61] != w.rec) report("recording", o_m_tdata[61], w.rec);
                if (o_m_tdata[63:62] != 2'b0) report("pad", o_m_tdata[63:62], 0);
            end
        end
    end

    // result-side backpressure
    int stall_n;
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_m_tready = 1'b1;
            stall_n = 0;
        end else if (stall_n > 0) begin
            i_m_tready = 1'b0;
            stall_n--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_m_tready = 1'b0;
            stall_n = $urandom_range(0, 8);
        end else begin
            i_m_tready = 1'b1;
        end
    end

    task automatic send(input t_action act, input logic [31:0] raw, input logic last,
                        input logic typed = 1'b0, input t_meter want = '0);
        t_meter p;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = act;
        i_s_tdata = raw;
        i_s_tlast = last;
        do @(posedge i_clk); while (!o_s_tready);
        p = meter_step(act, raw, last);
        meter_q.push_back(typed ? want : p);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (meter_q.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [14:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_NOISE_FLOOR) floor_q = val; else scale_q = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        logic [15:0] big, other;
        int lim;
        if ($urandom_range(0, 3) == 0) return $urandom;
        case ($urandom_range(0, 2))
            0: lim = 100;
            1: lim = 3000;
            default: lim = 32767;
        endcase
        big = 16'($urandom_range(0, lim));
        other = 16'($urandom_range(0, big));
        if ($urandom_range(0, 1)) big = -big;
        if ($urandom_range(0, 1)) other = -other;
        return $urandom_range(0, 1) ? {big, other} : {other, big};
    endfunction

    task automatic run_phase(input int n, input bit full_chunk);
        int r;
        send(ACT_START, $urandom, 1'b0);
        if (full_chunk)
            repeat (530) send(ACT_SAMPLE, rand_word(), 1'b0);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 88) send(ACT_SAMPLE, rand_word(), $urandom_range(0, 9) == 0);
            else if (r < 92) send(ACT_STOP, $urandom, $urandom_range(0, 1));
            else if (r < 96) send(ACT_START, $urandom, $urandom_range(0, 1));
            else send(ACT_NOP, $urandom, $urandom_range(0, 1));
        end
        drain();
    endtask

    t_row rows[$];

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = ACT_NOP; i_s_tlast = 1'b0;
        i_m_tready = 1'b1;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_NOISE_FLOOR; i_cfg_data = '0;
        quiet = 1'b0;
        n_err = 0; n_items = 0; n_results = 0; n_chunks = 0;
        floor_q = NOISE_RST; scale_q = SCALE_RST;
        rec_q = 0; level_q = 0; csum_q = 0; cpeak_q = 0; ccnt_q = 0;
        tcnt_q = 0; tsum_q = 0; tpeak_q = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        rows = '{
            '{ACT_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, '{0, 0, 0, 0, 0}},
            '{ACT_NOP,    32'hFFFF_FFFF, 1'b1, 1'b1, '{0, 0, 0, 0, 0}},
            '{ACT_START,  32'h0,         1'b1, 1'b1, '{0, 0, 0, 0, 1}},
            '{ACT_SAMPLE, 32'h8000_0000, 1'b1, 1'b1, '{70, 100, 32767, 1, 1}},
            '{ACT_SAMPLE, 32'h0000_8000, 1'b1, 1'b1, '{91, 100, 32767, 2, 1}},
            '{ACT_SAMPLE, 32'h0,         1'b1, 1'b1, '{81, 100, 32767, 3, 1}},
            '{ACT_SAMPLE, 32'hFFFF_0001, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 32'h0001_FFFF, 1'b1, 1'b0, '0},
            '{ACT_STOP,   32'h0,         1'b1, 1'b0, '0},
            '{ACT_SAMPLE, 32'h1234_5678, 1'b1, 1'b0, '0},
            '{ACT_START,  32'hFFFF_FFFF, 1'b0, 1'b1, '{0, 0, 0, 0, 1}},
            '{ACT_SAMPLE, 32'h0014_0014, 1'b1, 1'b0, '0},
            '{ACT_SAMPLE, 32'h0015_FFEB, 1'b1, 1'b0, '0},
            '{ACT_SAMPLE, 32'h7FFF_8001, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ACT_STOP,   32'h0,         1'b0, 1'b0, '0},
            '{ACT_NOP,    32'h0,         1'b0, 1'b0, '0},
            '{ACT_START,  32'h0,         1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 32'h0400_0400, 1'b1, 1'b0, '0}
        };
        foreach (rows[i])
            send(rows[i].act, rows[i].data, rows[i].last, rows[i].typed, rows[i].want);
        drain();

        write_reg(CFG_NOISE_FLOOR, 15'd0);
        write_reg(CFG_LEVEL_SCALE, 15'd1);
        run_phase(90, 1'b0);
        write_reg(CFG_NOISE_FLOOR, 15'h7FFF);
        write_reg(CFG_LEVEL_SCALE, 15'h7FFF);
        run_phase(60, 1'b0);
        write_reg(CFG_NOISE_FLOOR, 15'd50);
        write_reg(CFG_LEVEL_SCALE, 15'd0);
        run_phase(60, 1'b1);
        write_reg(CFG_NOISE_FLOOR, 15'd0);
        write_reg(CFG_LEVEL_SCALE, 15'h7FFF);
        run_phase(60, 1'b0);
        write_reg(CFG_NOISE_FLOOR, 15'($urandom_range(0, 500)));
        write_reg(CFG_LEVEL_SCALE, 15'($urandom_range(1, 300)));
        quiet = 1'b1;
        run_phase(60, 1'b0);

        $display("covered %0d input transactions, %0d results, %0d completed chunks",
                 n_items, n_results, n_chunks);
        $display("register settings: reset, both extremes, zero scale, random");
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/alm_pkg.sv
hdl/alm_ctrl.sv
hdl/alm_datapath.sv
hdl/audio_level_meter_core.sv
dv/tb.sv
